### hw/rtl/tweakable_gift64_cipher_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the tweakable GIFT-64 cipher
// Clock is clock, reset is reset (synchronous, active high).
// ---------------------------------------------------------------------------
`ifndef TWEAKABLE_GIFT64_CIPHER_MACROS_SVH
`define TWEAKABLE_GIFT64_CIPHER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TWG_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`define TWG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TWG_ASSERT(lbl, cond, msg)
`define TWG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### hw/rtl/twg_pkg.sv
// ---------------------------------------------------------------------------
// twg_pkg
// Constants, tables and round helper functions for the GIFT-64 cipher.
// ---------------------------------------------------------------------------
package twg_pkg;

   localparam int MAX_ROUNDS = 28;
   localparam int DEF_ROUNDS = 28;
   localparam int BLK_W      = 64;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 64;
   localparam int TWEAK_W    = 4;

   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_HIGH = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TWEAK    = 2'd2;

   localparam logic [3:0] SBOX_FWD [16] = '{4'h1, 4'ha, 4'h4, 4'hc, 4'h6, 4'hf, 4'h3, 4'h9,
                                           4'h2, 4'hd, 4'hb, 4'h7, 4'h5, 4'h0, 4'h8, 4'he};
   localparam logic [3:0] SBOX_INV [16] = '{4'hd, 4'h0, 4'h8, 4'h6, 4'h2, 4'hc, 4'h4, 4'hb,
                                           4'he, 4'h7, 4'h1, 4'ha, 4'h3, 4'h9, 4'hf, 4'h5};
   localparam logic [5:0] RCON [MAX_ROUNDS] = '{
      6'h01, 6'h03, 6'h07, 6'h0f, 6'h1f, 6'h3e, 6'h3d, 6'h3b, 6'h37, 6'h2f,
      6'h1e, 6'h3c, 6'h39, 6'h33, 6'h27, 6'h0e, 6'h1d, 6'h3a, 6'h35, 6'h2b,
      6'h16, 6'h2c, 6'h18, 6'h30, 6'h21, 6'h02, 6'h05, 6'h0b};

   function automatic int perm_pos(input int i);
      int q;
      q = i % 4;
      return 4 * (i / 16) + 16 * ((3 * ((i % 16) / 4) + q) % 4) + q;
   endfunction

   function automatic logic [BLK_W-1:0] sub_nibbles(input logic [BLK_W-1:0] x,
                                                    input logic inv);
      logic [BLK_W-1:0] r;
      r = '0;
      for (int i = 0; i < 16; i++) begin
         r[4*i +: 4] = inv ? SBOX_INV[x[4*i +: 4]] : SBOX_FWD[x[4*i +: 4]];
      end
      return r;
   endfunction

   function automatic logic [BLK_W-1:0] perm_fwd(input logic [BLK_W-1:0] x);
      logic [BLK_W-1:0] r;
      r = '0;
      for (int i = 0; i < BLK_W; i++) begin
         r[6'(perm_pos(i))] = x[i];
      end
      return r;
   endfunction

   function automatic logic [BLK_W-1:0] perm_inv(input logic [BLK_W-1:0] x);
      logic [BLK_W-1:0] r;
      r = '0;
      for (int i = 0; i < BLK_W; i++) begin
         r[i] = x[6'(perm_pos(i))];
      end
      return r;
   endfunction

   function automatic logic [BLK_W-1:0] expand_tweak(input logic [TWEAK_W-1:0] t);
      logic             p;
      logic [7:0]       b;
      logic [15:0]      w;
      logic [BLK_W-1:0] r;
      p = ^t;
      b = {t ^ {TWEAK_W{p}}, t};
      w = {b, b};
      r = '0;
      for (int i = 0; i < 15; i++) begin
         r[4*i+2] = w[i];
      end
      return r;
   endfunction

   // round word: key bits at 4j / 4j+1, constant at 4j+3, top bit set
   function automatic logic [BLK_W-1:0] build_rkey(input logic [31:0] kw,
                                                   input logic [4:0] rnd);
      logic [BLK_W-1:0] r;
      logic [5:0]       c;
      r = '0;
      r[BLK_W-1] = 1'b1;
      c = RCON[rnd];
      for (int j = 0; j < 16; j++) begin
         r[4*j]   = kw[j];
         r[4*j+1] = kw[16+j];
      end
      for (int j = 0; j < 6; j++) begin
         r[4*j+3] = c[j];
      end
      return r;
   endfunction

endpackage

### hw/rtl/twg_round.sv
// ---------------------------------------------------------------------------
// twg_round
// One encryption or decryption round, tweak insertion included.
// ---------------------------------------------------------------------------
module twg_round (
   input  logic                    decrypt,
   input  logic                    add_tweak,
   input  logic [twg_pkg::BLK_W-1:0] state_in,
   input  logic [twg_pkg::BLK_W-1:0] rkey,
   input  logic [twg_pkg::BLK_W-1:0] tweak,
   output logic [twg_pkg::BLK_W-1:0] state_out
);
   import twg_pkg::*;

   logic [BLK_W-1:0] enc_mix;
   logic [BLK_W-1:0] dec_pre;
   logic [BLK_W-1:0] enc_res;
   logic [BLK_W-1:0] dec_res;

   always_comb begin
      enc_mix   = perm_fwd(sub_nibbles(state_in, 1'b0)) ^ rkey;
      enc_res   = add_tweak ? (enc_mix ^ tweak) : enc_mix;
      // decryption removes the tweak before undoing the round
      dec_pre   = add_tweak ? (state_in ^ tweak) : state_in;
      dec_res   = sub_nibbles(perm_inv(dec_pre ^ rkey), 1'b1);
      state_out = decrypt ? dec_res : enc_res;
   end

endmodule

### hw/rtl/tweakable_gift64_cipher.sv
// ---------------------------------------------------------------------------
// tweakable_gift64_cipher
// Round-iterative tweakable GIFT-64 encrypt/decrypt core.
// ---------------------------------------------------------------------------
// Usage:
//  - Write key_low (index 0), key_high (index 1) and the tweak (index 2)
//    through the csr_ port while the core is idle.
//  - Request channel: req_kind (0 encrypt, 1 decrypt) and req_block_in,
//    one transfer per block. Response channel: rsp_block_out.
//  - Per block the key schedule first steps through the rounds, shifting the
//    128-bit key state 32 bits a cycle and writing one round key per cycle
//    into a ROUNDS-entry round-key memory. A prefetch state then reads the
//    first key (single read port, registered read data), and the rounds
//    follow one per key, in reverse key order for decryption.
//  - A new request is accepted only in the idle state, so the core works
//    on one block at a time.
//  - The response sits in an output register; a stalled receiver holds the
//    finished block in the core until the held response is taken.
//  - Reset clears the control state and configuration to zero.
// ---------------------------------------------------------------------------
`include "tweakable_gift64_cipher_macros.svh"

module tweakable_gift64_cipher #(
   parameter int ROUNDS = twg_pkg::DEF_ROUNDS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [twg_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [twg_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_kind,
   input  logic [twg_pkg::BLK_W-1:0]        req_block_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [twg_pkg::BLK_W-1:0]        rsp_block_out
);
   import twg_pkg::*;

   localparam int ADDR_W = $clog2(ROUNDS);
   localparam logic [ADDR_W-1:0] LAST = ADDR_W'(ROUNDS - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_KEYX = 3'd1;
   localparam logic [2:0] S_PREP = 3'd2;
   localparam logic [2:0] S_RUN  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [ADDR_W-1:0]    cnt_ff, cnt_in;
   logic                 kind_ff, kind_in;
   logic [BLK_W-1:0]     blk_ff, blk_in;
   logic [127:0]         ks_ff, ks_in;
   logic [BLK_W-1:0]     key_lo_ff, key_hi_ff;
   logic [TWEAK_W-1:0]   tweak_ff;
   logic [BLK_W-1:0]     tw_ff, tw_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BLK_W-1:0]     rsp_ff, rsp_in;

   logic [BLK_W-1:0]     rk_mem [ROUNDS];
   logic [BLK_W-1:0]     rk_rd_ff;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rnd;
   logic                 add_tw;
   logic [BLK_W-1:0]     round_out;
   logic [15:0]          ku, kv;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         key_lo_ff <= '0;
         key_hi_ff <= '0;
         tweak_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_KEY_LOW:  key_lo_ff <= csr_wdata;
            CSR_KEY_HIGH: key_hi_ff <= csr_wdata;
            CSR_TWEAK:    tweak_ff  <= csr_wdata[TWEAK_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_block_out = rsp_ff;

   assign rnd    = kind_ff ? (LAST - cnt_ff) : cnt_ff;
   assign add_tw = (rnd[1:0] == 2'b11) && (rnd != LAST);
   assign ku     = ks_ff[31:16];
   assign kv     = ks_ff[15:0];

   twg_round u_round (
      .decrypt   (kind_ff),
      .add_tweak (add_tw),
      .state_in  (blk_ff),
      .rkey      (rk_rd_ff),
      .tweak     (tw_ff),
      .state_out (round_out)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      kind_in      = kind_ff;
      blk_in       = blk_ff;
      ks_in        = ks_ff;
      tw_in        = tw_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               blk_in   = req_block_in;
               ks_in    = {key_hi_ff, key_lo_ff};
               tw_in    = expand_tweak(tweak_ff);
               cnt_in   = '0;
               state_in = S_KEYX;
            end
         end
         S_KEYX: begin
            ks_in = {ku[1:0], ku[15:2], kv[11:0], kv[15:12], ks_ff[127:32]};
            if (cnt_ff == LAST) begin
               cnt_in   = '0;
               state_in = S_PREP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_PREP: begin
            rd_en    = 1'b1;
            rd_addr  = kind_ff ? LAST : '0;
            state_in = S_RUN;
         end
         S_RUN: begin
            blk_in = round_out;
            if (cnt_ff == LAST) begin
               cnt_in   = '0;
               state_in = S_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = kind_ff ? (LAST - cnt_ff - 1'b1) : (cnt_ff + 1'b1);
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = blk_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // round-key memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (state_ff == S_KEYX) begin
         rk_mem[cnt_ff] <= build_rkey(ks_ff[31:0], 5'(cnt_ff));
      end
      if (rd_en) begin
         rk_rd_ff <= rk_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      blk_ff  <= blk_in;
      ks_ff   <= ks_in;
      tw_ff   <= tw_in;
      rsp_ff  <= rsp_in;
   end

   `TWG_ASSERT(a_cnt_range, cnt_ff <= LAST, "round counter beyond last round")
   `TWG_ASSERT_NEXT(a_start, req_valid && req_ready, state_ff == S_KEYX && cnt_ff == '0, "transfer did not start key schedule")
   `TWG_ASSERT_NEXT(a_run_end, state_ff == S_RUN && cnt_ff == LAST, state_ff == S_DONE, "last round did not finish")
   `TWG_ASSERT_NEXT(a_no_overwrite, state_ff == S_DONE && rsp_valid_ff && !rsp_ready, state_ff == S_DONE && rsp_valid_ff, "held response overwritten")

endmodule

### bench/tb.sv
// ---------------------------------------------------------------------------
// Tweakable GIFT-64 cipher testbench
// Drives encrypt/decrypt blocks under several key and tweak settings with
// random gaps and stalls, and checks each response against a cycle-free
// software model of the cipher.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import twg_pkg::*;

   localparam int NROUNDS   = 28;
   localparam int WD_LIMIT  = 20000;
   localparam int MAX_SHOWN = 10;
   localparam bit KIND_ENC  = 1'b0;
   localparam bit KIND_DEC  = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [63:0] blk;
   } block_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = 1'b0;
   logic [63:0] req_block_in = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_block_out;

   tweakable_gift64_cipher DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model copy of the configuration
   logic [63:0] cfg_key_lo, cfg_key_hi;
   logic [3:0]  cfg_tweak;

   block_req_type pending_blocks[$];
   logic [63:0] expected_blocks[$];
   int unsigned mismatches = 0, blocks_sent = 0, blocks_checked = 0;
   int unsigned blocks_queued = 0;
   int unsigned dec_count = 0, idle_cycles = 0;
   bit          stim_done = 1'b0;
   bit          long_stall = 1'b0;

   function automatic int bit_pos(int i);
      return 4 * (i / 16) + 16 * ((3 * ((i % 16) / 4) + i % 4) % 4) + i % 4;
   endfunction

   function automatic logic [63:0] gift_cipher(logic kind, logic [63:0] din);
      logic [63:0] rk[NROUNDS];
      logic [63:0] ks_lo, ks_hi, st, tmp, tw;
      logic [15:0] u, v, w16;
      logic [7:0]  tb8;
      logic [5:0]  rc[NROUNDS];
      logic [3:0]  fs[16], is[16];
      logic        par;
      fs = '{4'h1, 4'ha, 4'h4, 4'hc, 4'h6, 4'hf, 4'h3, 4'h9,
             4'h2, 4'hd, 4'hb, 4'h7, 4'h5, 4'h0, 4'h8, 4'he};
      is = '{4'hd, 4'h0, 4'h8, 4'h6, 4'h2, 4'hc, 4'h4, 4'hb,
             4'he, 4'h7, 4'h1, 4'ha, 4'h3, 4'h9, 4'hf, 4'h5};
      rc = '{6'h01, 6'h03, 6'h07, 6'h0f, 6'h1f, 6'h3e, 6'h3d, 6'h3b, 6'h37, 6'h2f,
             6'h1e, 6'h3c, 6'h39, 6'h33, 6'h27, 6'h0e, 6'h1d, 6'h3a, 6'h35, 6'h2b,
             6'h16, 6'h2c, 6'h18, 6'h30, 6'h21, 6'h02, 6'h05, 6'h0b};
      par = ^cfg_tweak;
      tb8 = {cfg_tweak ^ {4{par}}, cfg_tweak};
      w16 = {tb8, tb8};
      tw = '0;
      for (int i = 0; i < 15; i++) tw[4*i+2] = w16[i];
      ks_lo = cfg_key_lo;
      ks_hi = cfg_key_hi;
      for (int r = 0; r < NROUNDS; r++) begin
         u = ks_lo[31:16];
         v = ks_lo[15:0];
         rk[r] = 64'h8000_0000_0000_0000;
         for (int j = 0; j < 16; j++) begin
            rk[r][4*j+1] = u[j];
            rk[r][4*j]   = v[j];
         end
         for (int j = 0; j < 6; j++) rk[r][4*j+3] = rc[r][j];
         ks_lo = {ks_hi[31:0], ks_lo[63:32]};
         ks_hi = {{u[1:0], u[15:2]}, {v[11:0], v[15:12]}, ks_hi[63:32]};
      end
      st = din;
      if (kind == KIND_ENC) begin
         for (int r = 0; r < NROUNDS; r++) begin
            for (int n = 0; n < 16; n++) st[4*n +: 4] = fs[st[4*n +: 4]];
            tmp = '0;
            for (int i = 0; i < 64; i++) tmp[bit_pos(i)] = st[i];
            st = tmp ^ rk[r];
            if (r % 4 == 3 && r != NROUNDS - 1) st ^= tw;
         end
      end else begin
         for (int r = NROUNDS - 1; r >= 0; r--) begin
            if (r % 4 == 3 && r != NROUNDS - 1) st ^= tw;
            st ^= rk[r];
            tmp = '0;
            for (int i = 0; i < 64; i++) tmp[i] = st[bit_pos(i)];
            for (int n = 0; n < 16; n++) st[4*n +: 4] = is[tmp[4*n +: 4]];
         end
      end
      return st;
   endfunction

   function automatic logic [63:0] rand64();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return 64'h1 << $urandom_range(0, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // sender
   int unsigned req_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_blocks.push_back(gift_cipher(req_kind, req_block_in));
            blocks_sent++;
            if (req_kind == KIND_DEC) dec_count++;
            req_gap <= $urandom_range(0, 6);
         end
         if (!(req_valid && !req_ready)) begin
            if ((req_valid && req_ready) || req_gap != 0) begin
               if (!(req_valid && req_ready)) req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_blocks.size() != 0) begin
               block_req_type b;
               b = pending_blocks.pop_front();
               req_valid <= 1'b1;
               req_kind <= b.kind;
               req_block_in <= b.blk;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   int unsigned rsp_wait = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_blocks.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("unexpected response %h", rsp_block_out);
            end else begin
               logic [63:0] exp_blk;
               exp_blk = expected_blocks.pop_front();
               blocks_checked++;
               if (rsp_block_out !== exp_blk) begin
                  mismatches++;
                  if (mismatches <= MAX_SHOWN)
                     $display("block_out mismatch: expected %h got %h",
                              exp_blk, rsp_block_out);
               end
            end
            rsp_wait <= $urandom_range(0, 6);
            rsp_ready <= 1'b0;
         end else if (long_stall) begin
            rsp_ready <= 1'b0;
         end else if (rsp_wait != 0) begin
            rsp_wait <= rsp_wait - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset
          || long_stall || (stim_done && expected_blocks.size() == 0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_KEY_LOW:  cfg_key_lo = val;
         CSR_KEY_HIGH: cfg_key_hi = val;
         CSR_TWEAK:    cfg_tweak = val[3:0];
         default: ;
      endcase
   endtask

   // every queued block has come back and been checked
   task automatic drain();
      while (blocks_checked < blocks_queued)
         @(posedge clock);
      repeat (2 * NROUNDS + 8) @(posedge clock);
   endtask

   task automatic set_keys(logic [63:0] lo, logic [63:0] hi, logic [3:0] t);
      write_csr(CSR_KEY_LOW, lo);
      write_csr(CSR_KEY_HIGH, hi);
      write_csr(CSR_TWEAK, {60'h0, t});
   endtask

   task automatic queue_block(logic kind, logic [63:0] blk);
      block_req_type b;
      b.kind = kind;
      b.blk = blk;
      pending_blocks.push_back(b);
      blocks_queued++;
   endtask

   initial begin
      cfg_key_lo = '0;
      cfg_key_hi = '0;
      cfg_tweak = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // directed: zero config, extreme blocks, both directions
      queue_block(KIND_ENC, 64'h0);
      queue_block(KIND_ENC, '1);
      queue_block(KIND_DEC, 64'h0);
      queue_block(KIND_DEC, '1);
      queue_block(KIND_ENC, 64'h0123_4567_89ab_cdef);
      drain();
      set_keys('1, '1, 4'hf);
      queue_block(KIND_ENC, 64'h0);
      queue_block(KIND_DEC, '1);
      queue_block(KIND_ENC, 64'h8000_0000_0000_0001);
      drain();
      set_keys(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 4'h5);
      for (int i = 0; i < 8; i++) queue_block(i[0], rand64());
      // key schedule rerun per block: same block twice gives the same result
      queue_block(KIND_ENC, 64'hdead_beef_cafe_f00d);
      queue_block(KIND_ENC, 64'hdead_beef_cafe_f00d);
      drain();
      // random phases, config changed between phases
      for (int ph = 0; ph < 12; ph++) begin
         set_keys(rand64(), rand64(), 4'($urandom_range(0, 15)));
         if (ph == 5) write_csr(CSR_TWEAK, '1); // only low tweak bits kept
         for (int i = 0; i < 60; i++) queue_block(1'($urandom), rand64());
         if (ph == 3) begin
            // receiver held off while the sender keeps offering
            long_stall = 1'b1;
            repeat (400) @(posedge clock);
            long_stall = 1'b0;
         end
         if (ph == 7) begin
            // sender pause until all responses are in
            while (pending_blocks.size() != 0) @(posedge clock);
            while (blocks_checked < blocks_queued) @(posedge clock);
         end
         drain();
      end
      stim_done = 1'b1;
      $display("Sent %0d blocks (%0d decrypts) over 15 key/tweak settings; %0d checked.",
               blocks_sent, dec_count, blocks_checked);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/twg_pkg.sv
hw/rtl/twg_round.sv
hw/rtl/tweakable_gift64_cipher.sv
bench/tb.sv
